FILE: hdl/usd_pkg.sv
// Package for the UTF-8 stream decoder: shared constants, the decode
// request type passed from the front end to the back end, and byte class tests.
// No dependencies.
package usd_pkg;

    // Widths of the channel payloads.
    localparam int BYTE_W = 8;
    localparam int CP_W   = 16;

    // Depth of the request queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Number of bytes held by the front end while a sequence is open.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // Codepoint given in place of a malformed byte.
    localparam logic [CP_W-1:0] SUBST_CHAR = 16'h003F;

    // One decode request: a run of substitutes, then optionally one codepoint.
    typedef struct packed {
        logic [1:0]      subst_count;
        logic            has_cp;
        logic [CP_W-1:0] code_point;
        logic            text_end;
    } usd_cmd_t;

    // Byte of the form 10xxxxxx.
    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    // Lead byte of a two-byte form.
    function automatic logic is_lead2(input logic [BYTE_W-1:0] b);
        return (b & 8'hE0) == 8'hC0;
    endfunction

    // Lead byte of a three-byte form.
    function automatic logic is_lead3(input logic [BYTE_W-1:0] b);
        return (b & 8'hF0) == 8'hE0;
    endfunction

endpackage

FILE: hdl/usd_byte_if.sv
// Input channel of the UTF-8 stream decoder: one text byte per request.
// Depends on usd_pkg for the payload width.
interface usd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [usd_pkg::BYTE_W-1:0] text_byte;
    logic                      text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

FILE: hdl/usd_cp_if.sv
// Output channel of the UTF-8 stream decoder: one codepoint per request.
// Depends on usd_pkg for the payload width.
interface usd_cp_if;
    logic                    valid;
    logic                    ready;
    logic [usd_pkg::CP_W-1:0] code_point;
    logic                    substituted;
    logic                    run_last;
    logic                    text_done;

    modport source (output valid, output code_point, output substituted,
                    output run_last, output text_done, input ready);
    modport sink   (input valid, input code_point, input substituted,
                    input run_last, input text_done, output ready);
endinterface

FILE: hdl/usd_front.sv
// Front end of the UTF-8 stream decoder: takes bytes, tracks open sequences
// and gives at most one decode request per byte. Depends on usd_pkg, usd_byte_if.
module usd_front (
    input  logic              clk,
    input  logic              rst_n,
    usd_byte_if.sink          text_in,
    input  logic              queue_full,
    output logic              cmd_push,
    output usd_pkg::usd_cmd_t cmd
);
    import usd_pkg::*;

    logic [1:0]        pend_reg;
    logic [1:0]        pend_next;
    logic [BYTE_W-1:0] lead_reg;
    logic [BYTE_W-1:0] lead_next;
    logic [BYTE_W-1:0] mid_reg;
    logic [BYTE_W-1:0] mid_next;
    logic              accept;
    logic              do_start;
    logic [BYTE_W-1:0] b;

    assign text_in.ready = !queue_full;
    assign accept        = text_in.valid && text_in.ready;
    assign b             = text_in.text_byte;

    // Classify the byte against what is held and build its request.
    always_comb
    begin
        pend_next       = pend_reg;
        lead_next       = lead_reg;
        mid_next        = mid_reg;
        do_start        = 1'b0;
        cmd.subst_count = 2'd0;
        cmd.has_cp      = 1'b0;
        cmd.code_point  = {8'h00, b};
        cmd.text_end    = text_in.text_end;

        case (pend_reg)
            PEND_ONE:
            begin
                if (is_cont(b))
                begin
                    if (is_lead2(lead_reg))
                    begin
                        cmd.has_cp     = 1'b1;
                        cmd.code_point = {5'b00000, lead_reg[4:0], b[5:0]};
                        pend_next      = PEND_NONE;
                    end
                    else
                    begin
                        mid_next  = b;
                        pend_next = PEND_TWO;
                    end
                end
                else
                begin
                    cmd.subst_count = 2'd1;
                    pend_next       = PEND_NONE;
                    do_start        = 1'b1;
                end
            end
            PEND_TWO:
            begin
                if (is_cont(b))
                begin
                    cmd.has_cp     = 1'b1;
                    cmd.code_point = {lead_reg[3:0], mid_reg[5:0], b[5:0]};
                    pend_next      = PEND_NONE;
                end
                else
                begin
                    cmd.subst_count = 2'd2;
                    pend_next       = PEND_NONE;
                    do_start        = 1'b1;
                end
            end
            default:
            begin
                pend_next = PEND_NONE;
                do_start  = 1'b1;
            end
        endcase

        // The byte starts afresh: plain character, new lead or bad lead.
        if (do_start)
        begin
            if (!b[7])
            begin
                cmd.has_cp     = 1'b1;
                cmd.code_point = {8'h00, b};
            end
            else if (is_lead2(b) || is_lead3(b))
            begin
                lead_next = b;
                pend_next = PEND_ONE;
            end
            else
            begin
                cmd.subst_count = cmd.subst_count + 2'd1;
            end
        end

        // At the end of the text every byte still held becomes a substitute.
        if (text_in.text_end)
        begin
            cmd.subst_count = cmd.subst_count + pend_next;
            pend_next       = PEND_NONE;
        end
    end

    // A request goes to the queue only if the byte gives a result.
    assign cmd_push = accept && ((cmd.subst_count != 2'd0) || cmd.has_cp);

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    // Buffered bytes, meaningful only while a sequence is open.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lead_reg <= lead_next;
            mid_reg  <= mid_next;
        end
    end

endmodule

FILE: hdl/usd_queue.sv
// Short request queue between the front and back end of the UTF-8 decoder.
// Register based, first in first out. Depends on usd_pkg.
module usd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  usd_pkg::usd_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output usd_pkg::usd_cmd_t head_cmd
);
    import usd_pkg::*;

    usd_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;

    assign full       = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/usd_back.sv
// Back end of the UTF-8 decoder: expands each queued request into its
// results through a registered output stage. Depends on usd_pkg, usd_cp_if.
module usd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  usd_pkg::usd_cmd_t head_cmd,
    output logic              pop,
    usd_cp_if.source          code_out
);
    import usd_pkg::*;

    logic [1:0]      idx_reg;
    logic [1:0]      total;
    logic            last;
    logic            load;
    logic            out_valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            sub_reg;
    logic            run_last_reg;
    logic            done_reg;

    // Position within the request; the last result retires it.
    assign total = head_cmd.subst_count + {1'b0, head_cmd.has_cp};
    assign last  = idx_reg == (total - 2'd1);
    assign load  = head_valid && (!out_valid_reg || code_out.ready);
    assign pop   = load && last;

    assign code_out.valid       = out_valid_reg;
    assign code_out.code_point  = cp_reg;
    assign code_out.substituted = sub_reg;
    assign code_out.run_last    = run_last_reg;
    assign code_out.text_done   = done_reg;

    // Control: output valid and result index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (code_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: substitutes come first, then the decoded codepoint.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (idx_reg < head_cmd.subst_count)
            begin
                cp_reg  <= SUBST_CHAR;
                sub_reg <= 1'b1;
            end
            else
            begin
                cp_reg  <= head_cmd.code_point;
                sub_reg <= 1'b0;
            end
            run_last_reg <= last;
            done_reg     <= last && head_cmd.text_end;
        end
    end

endmodule

FILE: hdl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front end, request queue, back end.
// Depends on usd_pkg, usd_byte_if, usd_cp_if, usd_front, usd_queue, usd_back.
//
//   Channel    Dir  Payload                                          Request
//   text_in    in   text_byte[7:0], text_end                         one byte
//   code_out   out  code_point[15:0], substituted, run_last,         one codepoint
//                   text_done
//
// One byte is taken every cycle while each byte gives at most one result and
// the output is not stalled. A byte giving more than one result holds the
// output; the two-entry request queue absorbs that, and text_in.ready falls
// only when it is full. A result passes the queue, then the output register.
// Reset (rst_n low) empties the queue, clears the open sequence and the
// output valid; the decoder is ready as soon as reset is released.
module utf8_stream_decoder (
    input  logic     clk,
    input  logic     rst_n,
    usd_byte_if.sink text_in,
    usd_cp_if.source code_out
);
    import usd_pkg::*;

    usd_cmd_t cmd;
    usd_cmd_t head_cmd;
    logic     cmd_push;
    logic     queue_full;
    logic     head_valid;
    logic     pop;

    // Classify bytes into decode requests.
    usd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .queue_full (queue_full),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    // Decouple the two halves.
    usd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Expand requests into results.
    usd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .code_out   (code_out)
    );

endmodule

FILE: hdl/usd_checker.sv
// Port-level checks for the UTF-8 stream decoder, bound to its top level.
// Depends on usd_pkg and utf8_stream_decoder.
module usd_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [usd_pkg::CP_W-1:0] code_point,
    input logic                     substituted,
    input logic                     run_last,
    input logic                     text_done
);
    import usd_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(substituted) && $stable(run_last) && $stable(text_done))
        else $error("stalled result changed");

    // The end of the text closes the run of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_done |-> run_last)
        else $error("text_done without run_last");

    // A substitute always carries the replacement character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && substituted |-> code_point == SUBST_CHAR)
        else $error("substitute with wrong codepoint");

    // A decoded codepoint is always the final result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !substituted |-> run_last)
        else $error("decoded codepoint not last of its run");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (code_out.valid),
    .out_ready   (code_out.ready),
    .code_point  (code_out.code_point),
    .substituted (code_out.substituted),
    .run_last    (code_out.run_last),
    .text_done   (code_out.text_done)
);

FILE: verif/tb_top.sv
// Self-checking testbench for utf8_stream_decoder: random and directed byte streams,
// codepoints predicted in the bench and compared in order. Depends on usd_pkg,
// usd_byte_if, usd_cp_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
    import usd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 12;

    // One text byte waiting to be offered to the decoder.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              text_last;
    } text_req_t;

    // One decoded codepoint as it should leave the decoder.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            run_last;
        logic            text_done;
    } cp_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    usd_byte_if text_in();
    usd_cp_if   code_out();

    utf8_stream_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .code_out (code_out)
    );

    text_req_t  text_bytes[$];
    cp_result_t expected_cps[$];
    cp_result_t step_results[$];

    // Decoder state as the bench tracks it.
    logic [1:0]        dec_pending = PEND_NONE;
    logic [BYTE_W-1:0] dec_lead    = '0;
    logic [BYTE_W-1:0] dec_middle  = '0;

    int unsigned bytes_taken  = 0;
    int unsigned cps_checked  = 0;
    int unsigned subst_seen   = 0;
    int unsigned texts_closed = 0;
    int unsigned mismatches   = 0;
    int unsigned send_idle    = 0;
    int unsigned recv_stall   = 0;
    int unsigned quiet_cycles = 0;

    // Reset is held at the start; the driver and monitor set their outputs meanwhile.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Idle lengths: mostly none or short, a few long, and calm stretches with none.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if ((bytes_taken / 48) % 4 == 3)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void push_cp(input logic [CP_W-1:0] cp, input logic sub);
        cp_result_t r;
        r.code_point  = cp;
        r.substituted = sub;
        r.run_last    = 1'b0;
        r.text_done   = 1'b0;
        step_results.push_back(r);
    endfunction

    // A byte met with nothing buffered: plain character, new lead, or bad lead.
    function automatic void start_fresh(input logic [BYTE_W-1:0] b);
        if (!b[7])
            push_cp({8'h00, b}, 1'b0);
        else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110)
        begin
            dec_lead    = b;
            dec_pending = PEND_ONE;
        end
        else
            push_cp(SUBST_CHAR, 1'b1);
    endfunction

    // Works out the codepoints that one accepted byte gives and queues them.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic text_last);
        cp_result_t r;
        logic       cont;
        cont = (b[7:6] == 2'b10);
        step_results.delete();
        case (dec_pending)
            PEND_ONE:
            begin
                if (cont && dec_lead[7:5] == 3'b110)
                begin
                    push_cp({5'b0, dec_lead[4:0], b[5:0]}, 1'b0);
                    dec_pending = PEND_NONE;
                end
                else if (cont)
                begin
                    dec_middle  = b;
                    dec_pending = PEND_TWO;
                end
                else
                begin
                    push_cp(SUBST_CHAR, 1'b1);
                    dec_pending = PEND_NONE;
                    start_fresh(b);
                end
            end
            PEND_TWO:
            begin
                if (cont)
                begin
                    push_cp({dec_lead[3:0], dec_middle[5:0], b[5:0]}, 1'b0);
                    dec_pending = PEND_NONE;
                end
                else
                begin
                    // Both the lead and the buffered second byte are lost.
                    push_cp(SUBST_CHAR, 1'b1);
                    push_cp(SUBST_CHAR, 1'b1);
                    dec_pending = PEND_NONE;
                    start_fresh(b);
                end
            end
            default:
            begin
                dec_pending = PEND_NONE;
                start_fresh(b);
            end
        endcase

        // End of text flushes whatever is still buffered.
        if (text_last)
        begin
            if (dec_pending == PEND_ONE)
                push_cp(SUBST_CHAR, 1'b1);
            else if (dec_pending == PEND_TWO)
            begin
                push_cp(SUBST_CHAR, 1'b1);
                push_cp(SUBST_CHAR, 1'b1);
            end
            dec_pending = PEND_NONE;
            texts_closed++;
        end

        if (step_results.size() > 0)
        begin
            r = step_results.pop_back();
            r.run_last  = 1'b1;
            r.text_done = text_last;
            step_results.push_back(r);
        end
        foreach (step_results[i])
            expected_cps.push_back(step_results[i]);
    endfunction

    // Driver: offers queued bytes, predicting each request once it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        text_req_t nxt;
        if (!rst_n)
        begin
            text_in.valid     <= 1'b0;
            text_in.text_byte <= '0;
            text_in.text_end  <= 1'b0;
            send_idle         <= 0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                decode_byte(text_in.text_byte, text_in.text_end);
                bytes_taken++;
            end
            if (text_in.valid && !text_in.ready)
            begin
                // Hold the request until it is taken.
            end
            else if (send_idle > 0)
            begin
                send_idle     <= send_idle - 1;
                text_in.valid <= 1'b0;
            end
            else if (text_bytes.size() > 0)
            begin
                nxt               = text_bytes.pop_front();
                text_in.text_byte <= nxt.value;
                text_in.text_end  <= nxt.text_last;
                text_in.valid     <= 1'b1;
                send_idle         <= pick_gap();
            end
            else
                text_in.valid <= 1'b0;
        end
    end

    // Monitor: stalls the output at random and checks each codepoint in order.
    always @(posedge clk or negedge rst_n)
    begin
        cp_result_t want;
        if (!rst_n)
        begin
            code_out.ready <= 1'b0;
            recv_stall     <= 0;
        end
        else
        begin
            if (code_out.valid && code_out.ready)
            begin
                if (expected_cps.size() == 0)
                    report_mismatch($sformatf("codepoint %0h with nothing expected",
                                              code_out.code_point));
                else
                begin
                    want = expected_cps.pop_front();
                    if (code_out.code_point !== want.code_point)
                        report_mismatch($sformatf("code_point %0h, expected %0h",
                                                  code_out.code_point, want.code_point));
                    if (code_out.substituted !== want.substituted)
                        report_mismatch($sformatf("substituted %b, expected %b",
                                                  code_out.substituted, want.substituted));
                    if (code_out.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  code_out.run_last, want.run_last));
                    if (code_out.text_done !== want.text_done)
                        report_mismatch($sformatf("text_done %b, expected %b",
                                                  code_out.text_done, want.text_done));
                    if (want.substituted)
                        subst_seen++;
                end
                cps_checked++;
            end
            if (recv_stall > 0)
            begin
                recv_stall     <= recv_stall - 1;
                code_out.ready <= 1'b0;
            end
            else
            begin
                code_out.ready <= 1'b1;
                if (code_out.valid && code_out.ready)
                    recv_stall <= pick_gap();
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_in.valid && text_in.ready) || (code_out.valid && code_out.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("utf8_stream_decoder: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_byte(input logic [BYTE_W-1:0] value, input logic text_last);
        text_req_t t;
        t.value     = value;
        t.text_last = text_last;
        text_bytes.push_back(t);
    endtask

    // A random byte that is not of the continuation form.
    function automatic logic [BYTE_W-1:0] non_cont_byte();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
            b[6] = 1'b1;
        return b;
    endfunction

    // Stimulus, then the drain and the verdict.
    initial
    begin
        int unsigned random_bytes;
        int unsigned kind;
        logic [BYTE_W-1:0] b;

        // Directed: extremes, valid forms, overlong and surrogate forms, bad leads,
        // sequences broken at each position, and truncated text flushed at the end.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h3F, 1'b0);
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'hF5, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hE1, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'h41, 1'b1);

        // Random: mostly well-formed sequences with random content, some noise.
        random_bytes = 0;
        while (random_bytes < 405)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    add_byte(8'($urandom_range(0, 127)), $urandom_range(0, 15) == 0);
                    random_bytes += 1;
                end
                3, 4:
                begin
                    add_byte({3'b110, 5'($urandom_range(0, 31))}, $urandom_range(0, 31) == 0);
                    add_byte({2'b10, 6'($urandom_range(0, 63))}, $urandom_range(0, 15) == 0);
                    random_bytes += 2;
                end
                5, 6:
                begin
                    add_byte({4'b1110, 4'($urandom_range(0, 15))}, $urandom_range(0, 31) == 0);
                    add_byte({2'b10, 6'($urandom_range(0, 63))}, $urandom_range(0, 31) == 0);
                    add_byte({2'b10, 6'($urandom_range(0, 63))}, $urandom_range(0, 15) == 0);
                    random_bytes += 3;
                end
                7:
                begin
                    // Bad lead: a stray continuation byte or a byte of the form 1111xxxx.
                    if ($urandom_range(0, 1))
                        b = {2'b10, 6'($urandom_range(0, 63))};
                    else
                        b = {4'b1111, 4'($urandom_range(0, 15))};
                    add_byte(b, $urandom_range(0, 15) == 0);
                    random_bytes += 1;
                end
                8:
                begin
                    // Broken sequence: a lead, maybe one continuation, then a breaker.
                    if ($urandom_range(0, 1))
                    begin
                        add_byte({3'b110, 5'($urandom_range(0, 31))}, 1'b0);
                        random_bytes += 1;
                    end
                    else
                    begin
                        add_byte({4'b1110, 4'($urandom_range(0, 15))}, 1'b0);
                        random_bytes += 1;
                        if ($urandom_range(0, 1))
                        begin
                            add_byte({2'b10, 6'($urandom_range(0, 63))}, 1'b0);
                            random_bytes += 1;
                        end
                    end
                    add_byte(non_cont_byte(), $urandom_range(0, 7) == 0);
                    random_bytes += 1;
                end
                default:
                begin
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    random_bytes += 1;
                end
            endcase
        end

        // Wait for every byte to be taken and every codepoint to arrive.
        @(posedge clk);
        while (text_bytes.size() != 0 || text_in.valid || expected_cps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cps.size() != 0)
            report_mismatch($sformatf("%0d codepoints never arrived", expected_cps.size()));

        $display("Decoded %0d bytes into %0d codepoints, %0d of them substitutes.",
                 bytes_taken, cps_checked, subst_seen);
        $display("Closed %0d texts with random stalls on both channels.", texts_closed);
        if (mismatches == 0)
            $display("utf8_stream_decoder: match");
        else
            $display("utf8_stream_decoder: mismatch");
        $finish;
    end

endmodule
